[design/gpps_pkg.sv]
// Package with the shared codes and the controller/datapath interface types.
`timescale 1ns / 1ps

package gpps_pkg;

  // Selects the value that the primality test examines.
  localparam logic [1:0] V_T2 = 2'd0;
  localparam logic [1:0] V_P  = 2'd1;
  localparam logic [1:0] V_TP = 2'd2;

  // Which primality test is in flight.
  localparam logic [1:0] TEST_T2 = 2'd0;
  localparam logic [1:0] TEST_P  = 2'd1;
  localparam logic [1:0] TEST_TP = 2'd2;

  typedef struct packed {
    logic       load_target;
    logic       v_load;
    logic [1:0] v_sel;
    logic       p_init3;
    logic       p_step2;
    logic       p_set2;
    logic       prime_init;
    logic       prime_step;
    logic       div_start;
    logic       res_set;
    logic       res_found;
    logic       out_load;
  } gpps_cmd_t;

  typedef struct packed {
    logic half_lt2;
    logic t_odd;
    logic v_le1;
    logic v_even;
    logic v_is2;
    logic sq_gt_v;
    logic div_busy;
    logic div_done;
    logic rem_zero;
    logic p_gt_half;
  } gpps_sts_t;

endpackage

[design/gpps_rem_unit.sv]
// Restoring remainder unit that retires one dividend bit per cycle.
`timescale 1ns / 1ps

module gpps_rem_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] rem
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;

  assign partial = {rem, shreg[VALUE_WIDTH-1]};
  assign diff    = partial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (partial >= {1'b0, divisor}) begin
        rem <= diff[VALUE_WIDTH-1:0];
      end else begin
        rem <= partial[VALUE_WIDTH-1:0];
      end
    end
  end

endmodule

[design/gpps_datapath.sv]
// Datapath: target, candidate, trial divisor, its square, remainder unit and result register.
`timescale 1ns / 1ps

module gpps_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gpps_pkg::gpps_cmd_t    cmd,
  output gpps_pkg::gpps_sts_t    sts,
  input  logic [VALUE_WIDTH-1:0] target,
  output logic                   found,
  output logic [30:0]            smaller_prime,
  output logic [31:0]            larger_prime
);

  localparam int SW = VALUE_WIDTH + 2;

  logic [VALUE_WIDTH-1:0]    t;
  logic [VALUE_WIDTH-1:0]    p;
  logic [VALUE_WIDTH-1:0]    v;
  logic [VALUE_WIDTH-1:0]    d;
  logic [SW-1:0]             sq;
  logic                      res_found;
  logic [VALUE_WIDTH-1:0]    rem;
  logic [VALUE_WIDTH-1:0]    large_full;
  logic [VALUE_WIDTH+31:0]   p_ext;
  logic [VALUE_WIDTH+31:0]   large_ext;
  logic                      div_busy;
  logic                      div_done;

  assign large_full = t - p;
  assign p_ext      = {32'b0, p};
  assign large_ext  = {32'b0, large_full};

  always_comb begin
    sts.half_lt2  = (t[VALUE_WIDTH-1:2] == '0);
    sts.t_odd     = t[0];
    sts.v_le1     = (v[VALUE_WIDTH-1:1] == '0);
    sts.v_even    = ~v[0];
    sts.v_is2     = (v == VALUE_WIDTH'(2));
    sts.sq_gt_v   = (sq > {2'b00, v});
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.rem_zero  = (rem == '0);
    sts.p_gt_half = (p > {1'b0, t[VALUE_WIDTH-1:1]});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      t <= target;
    end
    if (cmd.p_set2) begin
      p <= VALUE_WIDTH'(2);
    end else if (cmd.p_init3) begin
      p <= VALUE_WIDTH'(3);
    end else if (cmd.p_step2) begin
      p <= p + VALUE_WIDTH'(2);
    end
    if (cmd.v_load) begin
      case (cmd.v_sel)
        gpps_pkg::V_T2: v <= t - VALUE_WIDTH'(2);
        gpps_pkg::V_P:  v <= p;
        gpps_pkg::V_TP: v <= large_full;
        default:        v <= p;
      endcase
    end
    if (cmd.prime_init) begin
      d  <= VALUE_WIDTH'(3);
      sq <= SW'(9);
    end else if (cmd.prime_step) begin
      d  <= d + VALUE_WIDTH'(2);
      sq <= sq + {d, 2'b00} + SW'(4);
    end
    if (cmd.res_set) begin
      res_found <= cmd.res_found;
    end
    if (cmd.out_load) begin
      found         <= res_found;
      smaller_prime <= res_found ? p_ext[30:0] : 31'd0;
      larger_prime  <= res_found ? large_ext[31:0] : 32'd0;
    end
  end

  gpps_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (v),
    .divisor  (d),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (rem)
  );

endmodule

[design/gpps_ctrl.sv]
// Controller state machine that sequences the candidate scan and the trial divisions.
`timescale 1ns / 1ps

module gpps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output gpps_pkg::gpps_cmd_t cmd,
  input  gpps_pkg::gpps_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_PINIT  = 3'd2;
  localparam logic [2:0] S_PCHK   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_CAND   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] which;
  logic [1:0] which_next;
  logic       prime;
  logic       prime_next;
  logic       out_valid_next;

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    state_next     = state;
    which_next     = which;
    prime_next     = prime;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_target = 1'b1;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.half_lt2) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.v_load = 1'b1;
          cmd.v_sel  = gpps_pkg::V_T2;
          which_next = gpps_pkg::TEST_T2;
          state_next = S_PINIT;
        end
      end
      S_PINIT: begin
        if (sts.v_le1) begin
          prime_next = 1'b0;
          state_next = S_DECIDE;
        end else if (sts.v_even) begin
          prime_next = sts.v_is2;
          state_next = S_DECIDE;
        end else begin
          cmd.prime_init = 1'b1;
          state_next     = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts.sq_gt_v) begin
          prime_next = 1'b1;
          state_next = S_DECIDE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            prime_next = 1'b0;
            state_next = S_DECIDE;
          end else begin
            cmd.prime_step = 1'b1;
            state_next     = S_PCHK;
          end
        end
      end
      S_DECIDE: begin
        case (which)
          gpps_pkg::TEST_T2: begin
            if (prime) begin
              cmd.p_set2    = 1'b1;
              cmd.res_set   = 1'b1;
              cmd.res_found = 1'b1;
              state_next    = S_DONE;
            end else if (sts.t_odd) begin
              cmd.res_set = 1'b1;
              state_next  = S_DONE;
            end else begin
              cmd.p_init3 = 1'b1;
              state_next  = S_CAND;
            end
          end
          gpps_pkg::TEST_P: begin
            if (prime) begin
              cmd.v_load = 1'b1;
              cmd.v_sel  = gpps_pkg::V_TP;
              which_next = gpps_pkg::TEST_TP;
              state_next = S_PINIT;
            end else begin
              cmd.p_step2 = 1'b1;
              state_next  = S_CAND;
            end
          end
          gpps_pkg::TEST_TP: begin
            if (prime) begin
              cmd.res_set   = 1'b1;
              cmd.res_found = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.p_step2 = 1'b1;
              state_next  = S_CAND;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            state_next  = S_DONE;
          end
        endcase
      end
      S_CAND: begin
        if (sts.p_gt_half) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.v_load = 1'b1;
          cmd.v_sel  = gpps_pkg::V_P;
          which_next = gpps_pkg::TEST_P;
          state_next = S_PINIT;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      which     <= gpps_pkg::TEST_T2;
      prime     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      which     <= which_next;
      prime     <= prime_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[design/goldbach_prime_pair_search_unit.sv]
// Top level of the Goldbach prime pair search unit.
// Sequence: the target is loaded on the input transfer, then each primality test of a
// value v runs trial divisions by odd divisors from 3 while their square does not exceed
// v, each done by the bit-serial remainder unit; candidates are scanned upward in odd steps.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous, active high; returns to idle with no result pending.
`timescale 1ns / 1ps

module goldbach_prime_pair_search_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] target,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [30:0]            smaller_prime,
  output logic [31:0]            larger_prime
);

  gpps_pkg::gpps_cmd_t cmd;
  gpps_pkg::gpps_sts_t sts;

  gpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gpps_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .target        (target),
    .found         (found),
    .smaller_prime (smaller_prime),
    .larger_prime  (larger_prime)
  );

  a_no_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (smaller_prime == 31'd0 && larger_prime == 32'd0))
    else $error("Empty result carries nonzero parts.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Second transfer taken while an item is in progress.");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("Division started while the remainder unit is busy.");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("Result register overwritten before its transfer.");

endmodule
